FILE: rtl/core/ipc_pkg.sv
// Shared types, character codes and operator tables for the infix to postfix core.
// Used by ipc_ctrl, ipc_datapath and infix_to_postfix_converter_core.
package ipc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);

  // operator codes as held on the stack
  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_PAREN = 3'd4;

  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    CLS_PLAIN,
    CLS_OPER,
    CLS_CLOSE,
    CLS_END
  } char_cls_t;

  typedef enum logic [2:0] {
    EM_SPACE,
    EM_TOP,
    EM_POPPED,
    EM_CHAR,
    EM_ERR
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      emit;
    emit_sel_t sel;
    logic      last;
    logic      clear_flags;
  } cmd_t;

  typedef struct packed {
    char_cls_t cls;
    logic      count_zero;
    logic      top_paren;
    logic      pop_ok;
    logic      full;
    logic      need_space;
    logic      slot_free;
  } status_t;

  function automatic logic [2:0] op_code(input logic [7:0] c);
    logic [2:0] code;
    case (c)
      CH_ADD:  code = OP_ADD;
      CH_SUB:  code = OP_SUB;
      CH_MUL:  code = OP_MUL;
      CH_DIV:  code = OP_DIV;
      default: code = OP_PAREN;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] op_char(input logic [2:0] code);
    logic [7:0] c;
    case (code)
      OP_ADD:   c = CH_ADD;
      OP_SUB:   c = CH_SUB;
      OP_MUL:   c = CH_MUL;
      OP_DIV:   c = CH_DIV;
      OP_PAREN: c = CH_OPEN;
      default:  c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_prec(input logic [2:0] code);
    logic [1:0] p;
    case (code)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_PAREN:       p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/core/ipc_datapath.sv
// Datapath: current character, operator stack, emit flags and output register.
// Depends on ipc_pkg; driven by commands from ipc_ctrl.
module ipc_datapath
  import ipc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_char,
  input  logic       in_end,
  input  cmd_t       cmd,
  output status_t    st,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic       out_error
);

  logic [7:0]       cur_char;
  logic             cur_end;
  logic [2:0]       stack [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  logic [2:0]       popped;
  logic             started;
  logic             last_space;

  logic [PTR_W-1:0] top_idx;
  logic [2:0]       top;
  logic [2:0]       cur_code;
  logic [7:0]       emit_char;

  assign top_idx  = PTR_W'(count - CNT_W'(1));
  assign top      = stack[top_idx];
  assign cur_code = op_code(cur_char);

  always_comb begin
    if (cur_end) begin
      st.cls = CLS_END;
    end else if (cur_char == CH_CLOSE) begin
      st.cls = CLS_CLOSE;
    end else if (cur_char == CH_ADD || cur_char == CH_SUB || cur_char == CH_MUL ||
                 cur_char == CH_DIV || cur_char == CH_OPEN) begin
      st.cls = CLS_OPER;
    end else begin
      st.cls = CLS_PLAIN;
    end
    st.count_zero = (count == '0);
    st.top_paren  = (top == OP_PAREN);
    st.pop_ok     = (count != '0) && (top != OP_PAREN) && (op_prec(top) >= op_prec(cur_code));
    st.full       = (count >= CNT_W'(STACK_DEPTH));
    st.need_space = started && !last_space;
    st.slot_free  = !out_valid || out_ready;
  end

  always_comb begin
    case (cmd.sel)
      EM_SPACE:  emit_char = CH_SPACE;
      EM_TOP:    emit_char = op_char(top);
      EM_POPPED: emit_char = op_char(popped);
      EM_CHAR:   emit_char = cur_char;
      default:   emit_char = CH_NUL;
    endcase
  end

  // stack contents and payload: no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_char <= in_char;
      cur_end  <= in_end;
    end
    if (cmd.push) begin
      stack[count[PTR_W-1:0]] <= cur_code;
    end
    if (cmd.pop) begin
      popped <= top;
    end
    if (cmd.emit) begin
      out_char  <= emit_char;
      out_last  <= cmd.last;
      out_error <= (cmd.sel == EM_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      started    <= 1'b0;
      last_space <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.push) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.clear_flags) begin
        started    <= 1'b0;
        last_space <= 1'b0;
      end else if (cmd.emit && cmd.sel != EM_ERR) begin
        started    <= 1'b1;
        last_space <= (emit_char == CH_SPACE);
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/ipc_ctrl.sv
// Controller FSM: sequences pops, pushes and character emission per input item.
// Depends on ipc_pkg; commands ipc_datapath.
module ipc_ctrl
  import ipc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT_CHAR,
    S_END_POP,
    S_END_OP,
    S_CLOSE_POP,
    S_CLOSE_OP,
    S_OP_SPACE,
    S_OP_POP,
    S_OP_SPACE2,
    S_ERR
  } state_t;

  state_t state, state_next;
  logic   more_ops;

  // another pop or an overflow error still follows
  assign more_ops = st.pop_ok || st.full;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = EM_SPACE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (st.cls)
          CLS_PLAIN: state_next = S_EMIT_CHAR;
          CLS_END:   state_next = S_END_POP;
          CLS_CLOSE: state_next = S_CLOSE_POP;
          default:   state_next = S_OP_SPACE;
        endcase
      end
      S_EMIT_CHAR: begin
        if (st.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = EM_CHAR;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_END_POP: begin
        if (st.count_zero) begin
          cmd.clear_flags = 1'b1;
          state_next      = S_IDLE;
        end else if (st.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.pop    = 1'b1;
          state_next = S_END_OP;
        end
      end
      S_END_OP: begin
        if (st.slot_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = EM_POPPED;
          cmd.last = st.count_zero;
          if (st.count_zero) begin
            cmd.clear_flags = 1'b1;
            state_next      = S_IDLE;
          end else begin
            state_next = S_END_POP;
          end
        end
      end
      S_CLOSE_POP: begin
        if (st.count_zero) begin
          state_next = S_ERR;
        end else if (st.top_paren) begin
          cmd.pop    = 1'b1;
          state_next = S_IDLE;
        end else if (st.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.pop    = 1'b1;
          state_next = S_CLOSE_OP;
        end
      end
      S_CLOSE_OP: begin
        if (st.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = EM_POPPED;
          cmd.last   = !st.count_zero && st.top_paren;
          state_next = S_CLOSE_POP;
        end
      end
      S_OP_SPACE: begin
        if (!st.need_space) begin
          state_next = S_OP_POP;
        end else if (st.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = !more_ops;
          state_next = S_OP_POP;
        end
      end
      S_OP_POP: begin
        if (st.pop_ok) begin
          if (st.slot_free) begin
            cmd.emit   = 1'b1;
            cmd.sel    = EM_TOP;
            cmd.pop    = 1'b1;
            state_next = S_OP_SPACE2;
          end
        end else if (st.full) begin
          state_next = S_ERR;
        end else begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_OP_SPACE2: begin
        if (st.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.last   = !more_ops;
          state_next = S_OP_POP;
        end
      end
      S_ERR: begin
        if (st.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = EM_ERR;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/core/infix_to_postfix_converter_core.sv
// Infix to postfix converter core: streamed shunting-yard with an operator stack.
// A transfer is loaded in S_IDLE and classified in S_EVAL before any result of it is registered.
// One transfer at a time: s_tready is high only in S_IDLE, so a new char waits until all pops,
//   emits and any error result of the previous one are done; output stalls hold the FSM.
// Reset (rst, synchronous): FSM idle, stack count and flags cleared; stack entries keep old data.
// Depends on ipc_pkg, ipc_ctrl and ipc_datapath.
module infix_to_postfix_converter_core
  import ipc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_in
  input  logic       s_tlast,   // is_end: flush stack and clear state
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_out
  output logic       m_tlast,   // last result of this input transfer
  output logic       m_tuser    // [0] error
);

  cmd_t    cmd;
  status_t st;

  // FSM takes one transfer at a time and steps the datapath through it
  ipc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // stack, flags and output register; the FSM waits on m_tready only while the register is full
  ipc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_char   (s_tdata),
    .in_end    (s_tlast),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (m_tdata),
    .out_last  (m_tlast),
    .out_error (m_tuser)
  );

endmodule
